// ===== hw/rtl/work_stealing_deque_bank_defines.svh =====
// Assertion macros used by the checker file wsdb_checker.sv.
// Each one samples on clk and is disabled while rst_n is low.
`ifndef WORK_STEALING_DEQUE_BANK_DEFINES_SVH
`define WORK_STEALING_DEQUE_BANK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSDB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsdb check failed");

// Consequent must hold in the cycle after the antecedent.
`define WSDB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsdb check failed");

`endif

// ===== hw/rtl/wsdb_pkg.sv =====
package wsdb_pkg;

  localparam int NUM_QUEUES     = 8;
  localparam int QUEUE_CAPACITY = 64;

  localparam int QID_W     = 3;
  localparam int ITEM_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int QSEL_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CNT_MOD   = 2 * QUEUE_CAPACITY;
  localparam int CNT_W     = $clog2(CNT_MOD);
  localparam int SLOT_W    = $clog2(QUEUE_CAPACITY);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_CAPACITY;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_PUSHED = 3'd0;
  localparam status_t ST_OWN    = 3'd1;
  localparam status_t ST_STOLEN = 3'd2;
  localparam status_t ST_NONE   = 3'd3;
  localparam status_t ST_REJECT = 3'd4;

  typedef struct packed {
    logic              op;
    logic [QID_W-1:0]  queue_id;
    logic [ITEM_W-1:0] item;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [ITEM_W-1:0] item_out;
    logic [QID_W-1:0]  source_queue;
  } out_item_t;

  typedef struct packed {
    logic load;  // capture the request being transferred
    logic exec;  // decide, update counters, access slot memory
  } ctrl_cmd_t;

endpackage

// ===== hw/rtl/wsdb_ctrl.sv =====
module wsdb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output wsdb_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECIDE = 3'b010,
    S_RESP   = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // a new request may be taken while the result is shown
        state_nxt = start ? S_DECIDE : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r == S_DECIDE);
  assign out_valid = (state_r == S_RESP);
  assign cmd.load  = start && !busy;
  assign cmd.exec  = (state_r == S_DECIDE);

endmodule

// ===== hw/rtl/wsdb_datapath.sv =====
module wsdb_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsdb_pkg::ctrl_cmd_t  cmd,
  input  wsdb_pkg::in_item_t   in_data,
  output wsdb_pkg::out_item_t  out_data
);

  typedef logic [wsdb_pkg::CNT_W-1:0]  cnt_t;
  typedef logic [wsdb_pkg::QSEL_W-1:0] qsel_t;

  function automatic cnt_t cnt_inc(input cnt_t c);
    return (c == cnt_t'(wsdb_pkg::CNT_MOD - 1)) ? '0 : c + 1'b1;
  endfunction

  function automatic cnt_t cnt_dec(input cnt_t c);
    return (c == '0) ? cnt_t'(wsdb_pkg::CNT_MOD - 1) : c - 1'b1;
  endfunction

  function automatic logic [wsdb_pkg::SLOT_W-1:0] cnt_slot(input cnt_t c);
    cnt_t d;
    d = c - cnt_t'(wsdb_pkg::QUEUE_CAPACITY);
    return (c >= cnt_t'(wsdb_pkg::QUEUE_CAPACITY)) ? d[wsdb_pkg::SLOT_W-1:0]
                                                   : c[wsdb_pkg::SLOT_W-1:0];
  endfunction

  function automatic cnt_t cnt_fill(input cnt_t b, input cnt_t t);
    logic [wsdb_pkg::CNT_W:0] w;
    if (b >= t) begin
      w = {1'b0, b} - {1'b0, t};
    end else begin
      w = {1'b0, b} + (wsdb_pkg::CNT_W + 1)'(wsdb_pkg::CNT_MOD) - {1'b0, t};
    end
    return w[wsdb_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [wsdb_pkg::QID_W-1:0] qsel_to_qid(input qsel_t q);
    logic [wsdb_pkg::QSEL_W+wsdb_pkg::QID_W-1:0] w;
    w = (wsdb_pkg::QSEL_W + wsdb_pkg::QID_W)'(q);
    return w[wsdb_pkg::QID_W-1:0];
  endfunction

  function automatic qsel_t qid_to_qsel(input logic [wsdb_pkg::QID_W-1:0] q);
    logic [wsdb_pkg::QSEL_W+wsdb_pkg::QID_W-1:0] w;
    w = (wsdb_pkg::QSEL_W + wsdb_pkg::QID_W)'(q);
    return w[wsdb_pkg::QSEL_W-1:0];
  endfunction

  wsdb_pkg::in_item_t in_r;

  cnt_t top_r   [wsdb_pkg::NUM_QUEUES];
  cnt_t bot_r   [wsdb_pkg::NUM_QUEUES];
  cnt_t top_nxt [wsdb_pkg::NUM_QUEUES];
  cnt_t bot_nxt [wsdb_pkg::NUM_QUEUES];

  logic [wsdb_pkg::NUM_QUEUES-1:0] empty;
  logic [wsdb_pkg::NUM_QUEUES-1:0] full;

  logic  own_valid;
  qsel_t own_q;
  logic  steal_found;
  qsel_t steal_q;

  logic  do_push;
  logic  do_pop;
  logic  do_steal;
  qsel_t sel_q;
  cnt_t  sel_top;
  cnt_t  sel_bot;
  cnt_t  mem_cnt;
  logic [wsdb_pkg::ADDR_W-1:0] mem_addr;
  logic  mem_we;
  logic  mem_re;

  wsdb_pkg::status_t status_nxt;
  wsdb_pkg::status_t status_r;
  logic [wsdb_pkg::QID_W-1:0] src_nxt;
  logic [wsdb_pkg::QID_W-1:0] src_r;

  logic [wsdb_pkg::ITEM_W-1:0] slot_mem [wsdb_pkg::MEM_DEPTH];
  logic [wsdb_pkg::ITEM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
  end

  always_comb begin
    for (int i = 0; i < wsdb_pkg::NUM_QUEUES; i++) begin
      empty[i] = (top_r[i] == bot_r[i]);
      full[i]  = (cnt_fill(bot_r[i], top_r[i]) == cnt_t'(wsdb_pkg::QUEUE_CAPACITY));
    end
  end

  // lowest-numbered non-empty queue other than the requester's own
  always_comb begin
    own_valid   = (32'(in_r.queue_id) < 32'(wsdb_pkg::NUM_QUEUES));
    own_q       = qid_to_qsel(in_r.queue_id);
    steal_found = 1'b0;
    steal_q     = '0;
    for (int i = wsdb_pkg::NUM_QUEUES - 1; i >= 0; i--) begin
      if (!empty[i] && !(own_valid && (qsel_t'(i) == own_q))) begin
        steal_found = 1'b1;
        steal_q     = qsel_t'(i);
      end
    end
  end

  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_steal   = 1'b0;
    sel_q      = own_q;
    status_nxt = wsdb_pkg::ST_NONE;
    priority if (in_r.op == wsdb_pkg::OP_PUSH) begin
      if (own_valid && !full[own_q]) begin
        do_push    = 1'b1;
        status_nxt = wsdb_pkg::ST_PUSHED;
      end else begin
        status_nxt = wsdb_pkg::ST_REJECT;
      end
    end else if (own_valid && !empty[own_q]) begin
      do_pop     = 1'b1;
      status_nxt = wsdb_pkg::ST_OWN;
    end else if (steal_found) begin
      do_steal   = 1'b1;
      sel_q      = steal_q;
      status_nxt = wsdb_pkg::ST_STOLEN;
    end else begin
      status_nxt = wsdb_pkg::ST_NONE;
    end
  end

  assign sel_top = top_r[sel_q];
  assign sel_bot = bot_r[sel_q];
  assign src_nxt = (do_pop || do_steal) ? qsel_to_qid(sel_q) : '0;

  always_comb begin
    if (do_steal) begin
      mem_cnt = sel_top;
    end else if (do_pop) begin
      mem_cnt = cnt_dec(sel_bot);
    end else begin
      mem_cnt = sel_bot;
    end
  end

  assign mem_addr = wsdb_pkg::ADDR_W'(int'(sel_q) * wsdb_pkg::QUEUE_CAPACITY
                                      + int'(cnt_slot(mem_cnt)));
  assign mem_we   = cmd.exec && do_push;
  assign mem_re   = cmd.exec && (do_pop || do_steal);

  always_comb begin
    top_nxt = top_r;
    bot_nxt = bot_r;
    if (cmd.exec) begin
      if (do_push) bot_nxt[sel_q] = cnt_inc(sel_bot);
      if (do_pop)  bot_nxt[sel_q] = cnt_dec(sel_bot);
      if (do_steal) top_nxt[sel_q] = cnt_inc(sel_top);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wsdb_pkg::NUM_QUEUES; i++) begin
        top_r[i] <= '0;
        bot_r[i] <= '0;
      end
    end else begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_addr] <= in_r.item;
    end
    if (mem_re) begin
      rd_data_r <= slot_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      src_r    <= src_nxt;
    end
  end

  assign out_data.status       = status_r;
  assign out_data.item_out     = ((status_r == wsdb_pkg::ST_OWN) ||
                                  (status_r == wsdb_pkg::ST_STOLEN)) ? rd_data_r : '0;
  assign out_data.source_queue = src_r;

endmodule

// ===== hw/rtl/work_stealing_deque_bank.sv =====
// A request transferred at a clock edge passes the decide cycle, then the result
// cycle, in which its result is strobed on out_valid. A new request may be
// transferred in the result cycle; busy is high only in the decide cycle, which
// holds the slot memory's single registered access and the counter update.
// Reset: synchronous rst_n clears the controller and all top/bottom counters;
// the slot memory is not cleared. Results cannot be stalled by the receiver.
module work_stealing_deque_bank (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wsdb_pkg::in_item_t  in_data,
  output logic                out_valid,
  output wsdb_pkg::out_item_t out_data
);

  wsdb_pkg::ctrl_cmd_t cmd;

  wsdb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  wsdb_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/wsdb_checker.sv =====
`include "work_stealing_deque_bank_defines.svh"

module wsdb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input wsdb_pkg::in_item_t  in_data,
  input logic                out_valid,
  input wsdb_pkg::out_item_t out_data
);

  logic no_delivery;
  logic in_xfer;
  logic fields_zero;
  logic fetch_op;
  logic is_pushed;

  assign in_xfer     = start && !busy;
  assign no_delivery = (out_data.status == wsdb_pkg::ST_PUSHED) ||
                       (out_data.status == wsdb_pkg::ST_NONE) ||
                       (out_data.status == wsdb_pkg::ST_REJECT);
  assign fields_zero = (out_data.item_out == '0) && (out_data.source_queue == '0);
  assign fetch_op    = (in_data.op == wsdb_pkg::OP_FETCH);
  assign is_pushed   = (out_data.status == wsdb_pkg::ST_PUSHED);

  `WSDB_ASSERT_NEXT(a_xfer_goes_busy, in_xfer, busy)
  `WSDB_ASSERT_NEXT(a_busy_then_result, busy, out_valid && !busy)
  `WSDB_ASSERT_NEXT(a_no_spurious_result, !busy && !start, !out_valid)
  `WSDB_ASSERT_NOW(a_empty_fields_zero, out_valid && no_delivery, fields_zero)
  // $past picks the op of the request behind a result, as sampled at its transfer
  `WSDB_ASSERT_NOW(a_fetch_not_pushed, out_valid && $past(fetch_op, 2), !is_pushed)

endmodule

bind work_stealing_deque_bank wsdb_checker u_wsdb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
